// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/ffd_pkg.sv -----
// shared constants, types and register indexes of the fractional feedback delay
package ffd_pkg;

  localparam int BufferDepth  = 131072;
  localparam int FilterStages = 4;
  localparam int FRAC_W       = 24;
  localparam int ADDR_W       = $clog2(BufferDepth);
  localparam int SPAN_W       = ADDR_W + 1;
  localparam int CD_W         = 25;
  localparam int POS_W        = ADDR_W + FRAC_W + 3;
  localparam int STG_W        = (FilterStages > 1) ? $clog2(FilterStages) : 1;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DLY_GOAL        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_AMOUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_READ_OFFSET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_SHIFT    = 3'd4;

  // reset values
  localparam logic [7:0]       RST_DLY_GOAL        = 8'd13;
  localparam logic [7:0]       RST_FEEDBACK_AMOUNT = 8'd0;
  localparam logic [7:0]       RST_FILTER_WEIGHT   = 8'd64;
  localparam logic [12:0]      RST_READ_OFFSET     = 13'd256;
  localparam logic [4:0]       RST_SMOOTH_SHIFT    = 5'd15;
  localparam logic [CD_W-1:0]  RST_CUR_DELAY       = 25'd1677722;
  localparam logic [7:0]       WEIGHT_ONE          = 8'd128;

  typedef struct packed {
    logic [7:0]  dly_goal;
    logic [7:0]  feedback_amount;
    logic [7:0]  filter_weight;
    logic [12:0] read_offset;
    logic [4:0]  smooth_shift;
  } cfg_t;

  // one classified word handed from front to back
  typedef struct packed {
    logic signed [15:0] sample;
    logic [ADDR_W-1:0]  idx0;
    logic [ADDR_W-1:0]  idx1;
    logic [FRAC_W-1:0]  frac;
    logic [ADDR_W-1:0]  wp;
    logic               ok0;
    logic               ok1;
  } qent_t;

  function automatic logic [7:0] sat128(input logic [7:0] v);
    return (v > WEIGHT_ONE) ? WEIGHT_ONE : v;
  endfunction

endpackage

// ----- src/ffd_ram.sv -----
// generic single-port-write ram with registered read
module ffd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/ffd_queue.sv -----
// two-entry queue between front and back
module ffd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ffd_pkg::qent_t push_data,
  output logic          full,
  input  logic          pop,
  output ffd_pkg::qent_t head,
  output logic          empty
);

  ffd_pkg::qent_t ent_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ----- src/ffd_front.sv -----
// front: delay glide, read position, wrap and fill tracking
module ffd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   in_sample_in,
  input  ffd_pkg::cfg_t        cfg,
  output logic                 q_push,
  output ffd_pkg::qent_t       q_data,
  input  logic                 q_full
);

  localparam int AW   = ffd_pkg::ADDR_W;
  localparam int FW   = ffd_pkg::FRAC_W;
  localparam int PW   = ffd_pkg::POS_W;
  localparam int SW   = ffd_pkg::SPAN_W;
  localparam int CW   = ffd_pkg::CD_W;
  localparam int PRW  = CW + SW;
  localparam logic signed [PW-1:0] Modulus = PW'(ffd_pkg::BufferDepth) << FW;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_SUM, F_WRAP} fstate_t;

  fstate_t              state_r;
  logic signed [15:0]   x_r;
  logic [CW-1:0]        cd_r;
  logic [PRW-1:0]       prod_r;
  logic signed [PW-1:0] pos_r;
  logic [AW-1:0]        wp_r;
  logic                 full_r;

  logic [CW-1:0]        tgt;
  logic signed [CW:0]   diff;
  logic signed [CW:0]   step;
  logic [SW-1:0]        off_s;
  logic [SW-1:0]        span;
  logic signed [PW-1:0] pos_sum;
  logic signed [PW-1:0] pos_wr;
  logic [AW-1:0]        idx0;
  logic [AW-1:0]        idx1;

  // glide step toward the target
  always_comb begin
    tgt  = CW'(ffd_pkg::sat128(cfg.dly_goal)) << 17;
    diff = $signed({1'b0, tgt}) - $signed({1'b0, cd_r});
    step = diff >>> cfg.smooth_shift;
  end

  // saturated offset and span
  always_comb begin
    if (32'(cfg.read_offset) > 32'(ffd_pkg::BufferDepth)) begin
      off_s = SW'(ffd_pkg::BufferDepth);
    end else begin
      off_s = SW'(cfg.read_offset);
    end
    span = SW'(ffd_pkg::BufferDepth) - off_s;
  end

  // raw position and wrap into the buffer
  always_comb begin
    pos_sum = $signed(PW'({wp_r, FW'(0)})) - $signed(PW'(prod_r))
            + $signed(PW'({off_s, FW'(0)}));
    if (pos_r[PW-1]) begin
      pos_wr = pos_r + Modulus;
    end else if (pos_r >= Modulus) begin
      pos_wr = pos_r - Modulus;
    end else begin
      pos_wr = pos_r;
    end
    idx0 = pos_wr[AW+FW-1:FW];
    idx1 = (idx0 == AW'(ffd_pkg::BufferDepth - 1)) ? '0 : idx0 + AW'(1);
  end

  assign in_ready = (state_r == F_IDLE);
  assign q_push   = (state_r == F_WRAP) && !q_full;

  // classified word
  always_comb begin
    q_data.sample = x_r;
    q_data.idx0   = idx0;
    q_data.idx1   = idx1;
    q_data.frac   = pos_wr[FW-1:0];
    q_data.wp     = wp_r;
    q_data.ok0    = full_r || (idx0 < wp_r);
    q_data.ok1    = full_r || (idx1 < wp_r);
  end

  // sequencer and front state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cd_r    <= ffd_pkg::RST_CUR_DELAY;
      wp_r    <= '0;
      full_r  <= 1'b0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            x_r     <= in_sample_in;
            cd_r    <= cd_r + step[CW-1:0];
            state_r <= F_MUL;
          end
        end
        F_MUL: begin
          prod_r  <= PRW'(cd_r) * PRW'(span);
          state_r <= F_SUM;
        end
        F_SUM: begin
          pos_r   <= pos_sum;
          state_r <= F_WRAP;
        end
        F_WRAP: begin
          if (!q_full) begin
            if (wp_r == AW'(ffd_pkg::BufferDepth - 1)) begin
              wp_r   <= '0;
              full_r <= 1'b1;
            end else begin
              wp_r <= wp_r + AW'(1);
            end
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- src/ffd_back.sv -----
// back: interpolation, low-pass cascade, feedback write and result register
module ffd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ffd_pkg::cfg_t      cfg,
  input  ffd_pkg::qent_t     q_head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample_out
);

  localparam int AW = ffd_pkg::ADDR_W;
  localparam int KW = ffd_pkg::STG_W;

  typedef enum logic [3:0] {
    B_IDLE, B_RA0, B_RA1, B_RD1, B_IM, B_IA, B_F1, B_F2, B_F3, B_O1, B_O2, B_O3
  } bstate_t;

  bstate_t              state_r;
  ffd_pkg::qent_t       ent_r;
  logic signed [15:0]   s0_r;
  logic signed [15:0]   s1_r;
  logic signed [23:0]   v_r;
  logic signed [23:0]   st_r [ffd_pkg::FilterStages];
  logic [KW-1:0]        k_r;
  logic signed [42:0]   mul_r;
  logic signed [42:0]   p1_r;
  logic                 out_valid_r;
  logic signed [15:0]   out_r;

  logic signed [24:0]   op_a;
  logic signed [17:0]   op_b;
  logic signed [16:0]   sdiff;
  logic signed [43:0]   acc;
  logic [7:0]           ws;
  logic [7:0]           fs;
  logic signed [15:0]   y;
  logic                 ram_we;
  logic [AW-1:0]        raddr;
  logic [15:0]          rdata;

  assign ws    = ffd_pkg::sat128(cfg.filter_weight);
  assign fs    = ffd_pkg::sat128(cfg.feedback_amount);
  assign sdiff = 17'(s1_r) - 17'(s0_r);
  assign y     = v_r[23:8];
  assign acc   = 44'(p1_r) + 44'(mul_r);
  assign raddr = (state_r == B_RA1) ? ent_r.idx1 : ent_r.idx0;
  assign ram_we = (state_r == B_O3) && (!out_valid_r || out_ready);
  assign q_pop  = (state_r == B_IDLE) && !q_empty;

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;

  ffd_ram #(.WIDTH(16), .DEPTH(ffd_pkg::BufferDepth)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ent_r.wp),
    .wdata (acc[22:7]),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared multiplier operand select, feedback product held while stalled
  always_comb begin
    case (state_r)
      B_IM: begin
        op_a = $signed({1'b0, ent_r.frac});
        op_b = 18'(sdiff);
      end
      B_F1: begin
        op_a = 25'(v_r);
        op_b = $signed({10'b0, ws});
      end
      B_F2: begin
        op_a = 25'(st_r[k_r]);
        op_b = $signed({10'b0, ffd_pkg::WEIGHT_ONE - ws});
      end
      B_O1: begin
        op_a = 25'(ent_r.sample);
        op_b = $signed({10'b0, ffd_pkg::WEIGHT_ONE - fs});
      end
      B_O2, B_O3: begin
        op_a = 25'(y);
        op_b = $signed({10'b0, fs});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // sequencer, datapath registers and result register
  always_ff @(posedge clk) begin
    mul_r <= op_a * op_b;
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      for (int i = 0; i < ffd_pkg::FilterStages; i++) begin
        st_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_ready && state_r != B_O3) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            ent_r   <= q_head;
            state_r <= B_RA0;
          end
        end
        B_RA0: state_r <= B_RA1;
        B_RA1: begin
          s0_r    <= ent_r.ok0 ? $signed(rdata) : 16'sd0;
          state_r <= B_RD1;
        end
        B_RD1: begin
          s1_r    <= ent_r.ok1 ? $signed(rdata) : 16'sd0;
          state_r <= B_IM;
        end
        B_IM: state_r <= B_IA;
        B_IA: begin
          v_r     <= {s0_r, 8'b0} + mul_r[39:16];
          k_r     <= '0;
          state_r <= B_F1;
        end
        B_F1: state_r <= B_F2;
        B_F2: begin
          p1_r    <= mul_r;
          state_r <= B_F3;
        end
        B_F3: begin
          v_r       <= acc[30:7];
          st_r[k_r] <= acc[30:7];
          if (k_r == KW'(ffd_pkg::FilterStages - 1)) begin
            state_r <= B_O1;
          end else begin
            k_r     <= k_r + KW'(1);
            state_r <= B_F1;
          end
        end
        B_O1: state_r <= B_O2;
        B_O2: begin
          p1_r    <= mul_r;
          state_r <= B_O3;
        end
        B_O3: begin
          if (!out_valid_r || out_ready) begin
            out_r       <= y;
            out_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- src/fractional_feedback_delay_top.sv -----
// top level: configuration registers, front, queue and back
// the back takes one word at a time through its shared multiplier
// sequence (interpolation, two products per low-pass stage, two for feedback)
// the front can run ahead of the back while the two-entry queue has room
// reset (synchronous, rst_n low) clears control, filter state and registers to
// defaults; the delay line needs no clearing pass, unwritten entries read as zero
module fractional_feedback_delay_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [15:0]                 in_sample_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [15:0]                 out_sample_out,
  input  logic                               cfg_we,
  input  logic [ffd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ffd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  ffd_pkg::cfg_t  cfg_r;
  ffd_pkg::qent_t q_in;
  ffd_pkg::qent_t q_head;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dly_goal        <= ffd_pkg::RST_DLY_GOAL;
      cfg_r.feedback_amount <= ffd_pkg::RST_FEEDBACK_AMOUNT;
      cfg_r.filter_weight   <= ffd_pkg::RST_FILTER_WEIGHT;
      cfg_r.read_offset     <= ffd_pkg::RST_READ_OFFSET;
      cfg_r.smooth_shift    <= ffd_pkg::RST_SMOOTH_SHIFT;
    end else if (cfg_we) begin
      case (cfg_index)
        ffd_pkg::REG_DLY_GOAL:        cfg_r.dly_goal        <= cfg_wdata[7:0];
        ffd_pkg::REG_FEEDBACK_AMOUNT: cfg_r.feedback_amount <= cfg_wdata[7:0];
        ffd_pkg::REG_FILTER_WEIGHT:   cfg_r.filter_weight   <= cfg_wdata[7:0];
        ffd_pkg::REG_READ_OFFSET:     cfg_r.read_offset     <= cfg_wdata[12:0];
        ffd_pkg::REG_SMOOTH_SHIFT:    cfg_r.smooth_shift    <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  ffd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample_in (in_sample_in),
    .cfg          (cfg_r),
    .q_push       (q_push),
    .q_data       (q_in),
    .q_full       (q_full)
  );

  ffd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  ffd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_head         (q_head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out)
  );

endmodule

// ----- src/ffd_checker.sv -----
// port-level checker for the fractional feedback delay, bound to the top level
`include "assert_macros.svh"

module ffd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [15:0]             out_sample_out
);

  logic [3:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 4'd0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 4'd1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 4'd1;
    end
  end

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `ASSERT_CLK(a_out_stable, out_valid && !out_ready |=> $stable(out_sample_out), "stalled result changed")
  `ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "result shown right after reset")
  `ASSERT_CLK(a_no_extra, out_valid |-> pend_r != 4'd0 && pend_r <= 4'd5, "result without pending word")

endmodule

bind fractional_feedback_delay_top ffd_checker u_ffd_checker (.*);

// ----- bench/tb_top.sv -----
// testbench for the fractional feedback delay: directed table, random words, predictor check
`timescale 1ns / 100ps
module tb_top;

  localparam longint OneQ24 = 64'sd1 << ffd_pkg::FRAC_W;
  localparam longint WrapQ24 = longint'(ffd_pkg::BufferDepth) * OneQ24;
  localparam logic [ffd_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd5;
  localparam int StallLimit = 20000;
  localparam int HoldCycles = 400;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_sample_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_sample_out;
  logic cfg_we = 1'b0;
  logic [ffd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ffd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state
  shortint line_mem[ffd_pkg::BufferDepth];
  int unsigned wr_ptr;
  longint cur_delay;
  longint lp_state[ffd_pkg::FilterStages];
  int unsigned m_target, m_feedback, m_weight, m_offset, m_shift;

  logic signed [15:0] pending_samples[$];
  idle_mode_t idle_mode = IDLE_NONE;
  bit hold_req = 0;
  int hold_cnt = 0;
  int mismatches = 0;
  int words_in = 0;
  int words_out = 0;
  int quiet_cycles = 0;

  fractional_feedback_delay_top dut (.*);

  always #4 clk = ~clk;

  function automatic longint sat_weight(int unsigned v);
    return (v > 128) ? 128 : v;
  endfunction

  // one sample through the delay, filter cascade and feedback write
  function automatic logic signed [15:0] delay_sample(logic signed [15:0] x);
    longint tgt, off, span, pos, frac, s0, s1, v, y, w, f, xin;
    int unsigned i0, i1;
    tgt = sat_weight(m_target) << 17;
    off = (m_offset > ffd_pkg::BufferDepth) ? ffd_pkg::BufferDepth : m_offset;
    span = ffd_pkg::BufferDepth - off;
    w = sat_weight(m_weight);
    f = sat_weight(m_feedback);
    xin = x;
    cur_delay = cur_delay + ((tgt - cur_delay) >>> m_shift);
    pos = longint'(wr_ptr) * OneQ24 - cur_delay * span + off * OneQ24;
    pos = pos % WrapQ24;
    if (pos < 0) pos = pos + WrapQ24;
    i0 = 32'(pos >>> ffd_pkg::FRAC_W);
    if (i0 >= ffd_pkg::BufferDepth) i0 = 0;
    i1 = (i0 + 1) % ffd_pkg::BufferDepth;
    frac = pos & (OneQ24 - 1);
    s0 = line_mem[i0];
    s1 = line_mem[i1];
    v = s0 * 256 + (((s1 - s0) * frac) >>> 16);
    for (int k = 0; k < ffd_pkg::FilterStages; k++) begin
      v = (w * v + (128 - w) * lp_state[k]) >>> 7;
      lp_state[k] = v;
    end
    y = v >>> 8;
    line_mem[wr_ptr] = shortint'((xin * (128 - f) + y * f) >>> 7);
    wr_ptr = (wr_ptr + 1) % ffd_pkg::BufferDepth;
    return y[15:0];
  endfunction

  task automatic report_mismatch(string what, logic signed [15:0] got, logic signed [15:0] want);
    $display("mismatch %s at word %0d: got %0d expected %0d", what, words_out, got, want);
    mismatches++;
  endtask

  // register write, mirrored into the predictor
  task automatic write_reg(logic [ffd_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[ffd_pkg::CFG_DATA_W-1:0];
    case (idx)
      ffd_pkg::REG_DLY_GOAL: m_target = val & 'hFF;
      ffd_pkg::REG_FEEDBACK_AMOUNT: m_feedback = val & 'hFF;
      ffd_pkg::REG_FILTER_WEIGHT: m_weight = val & 'hFF;
      ffd_pkg::REG_READ_OFFSET: m_offset = val & 'h1FFF;
      ffd_pkg::REG_SMOOTH_SHIFT: m_shift = val & 'h1F;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_all(int unsigned tg, int unsigned fb, int unsigned wt, int unsigned of,
                         int unsigned sh);
    write_reg(ffd_pkg::REG_DLY_GOAL, tg);
    write_reg(ffd_pkg::REG_FEEDBACK_AMOUNT, fb);
    write_reg(ffd_pkg::REG_FILTER_WEIGHT, wt);
    write_reg(ffd_pkg::REG_READ_OFFSET, of);
    write_reg(ffd_pkg::REG_SMOOTH_SHIFT, sh);
  endtask

  // offer one word, hold it until taken, then maybe go idle
  task automatic send_word(logic signed [15:0] s, bit typed, logic signed [15:0] want);
    logic signed [15:0] pred;
    in_valid <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = delay_sample(s);
    pending_samples.push_back(typed ? want : pred);
    words_in++;
    if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
      while ($urandom_range(99) < ((idle_mode == IDLE_SEND) ? 88 : 25)) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // receiver readiness and the long hold-off
  always @(posedge clk) begin
    if (hold_req && hold_cnt == 0) hold_cnt <= HoldCycles;
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (idle_mode == IDLE_RECV) begin
      out_ready <= ($urandom_range(99) >= 88);
    end else if (idle_mode == IDLE_BOTH) begin
      out_ready <= ($urandom_range(99) >= 25);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected word", out_sample_out, 16'sd0);
      end else begin
        if (out_sample_out !== pending_samples[0])
          report_mismatch("sample_out", out_sample_out, pending_samples[0]);
        void'(pending_samples.pop_front());
      end
      words_out++;
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no progress for %0d cycles", StallLimit);
      $display("[fractional_feedback_delay_top] ERROR");
      $finish;
    end
  end

  typedef struct {
    logic signed [15:0] sample;
    bit typed;
    logic signed [15:0] want;
  } dir_row_t;

  dir_row_t dir_rows[$] = '{
    '{16'sh8000, 1, 16'sd0}, '{16'sh7FFF, 1, 16'sd0}, '{16'sd0, 1, 16'sd0},
    '{-16'sd1, 1, 16'sd0}, '{16'sd1, 1, 16'sd0}, '{16'sh5555, 1, 16'sd0},
    '{16'shAAAA, 1, 16'sd0}, '{16'sh7FFF, 1, 16'sd0}, '{16'sh8000, 1, 16'sd0},
    '{16'sh7FFF, 0, 16'sd0}, '{16'sh8000, 0, 16'sd0}, '{16'sh7FFF, 0, 16'sd0}
  };

  // phase settings: target, feedback, weight, offset, shift
  int unsigned phase_cfg[8][5] = '{
    '{1, 0, 128, 1000, 0},
    '{1, 128, 100, 1010, 0},
    '{'h1F81, 200, 255, 1005, 2},
    '{2, 64, 1, 2030, 31},
    '{0, 255, 0, 0, 0},
    '{128, 30, 90, 4096, 24},
    '{1, 96, 77, 'h1FFF, 5},
    '{1, 120, 128, 1016, 1}
  };

  initial begin
    foreach (line_mem[i]) line_mem[i] = 0;
    foreach (lp_state[k]) lp_state[k] = 0;
    wr_ptr = 0;
    cur_delay = ffd_pkg::RST_CUR_DELAY;
    m_target = ffd_pkg::RST_DLY_GOAL;
    m_feedback = ffd_pkg::RST_FEEDBACK_AMOUNT;
    m_weight = ffd_pkg::RST_FILTER_WEIGHT;
    m_offset = ffd_pkg::RST_READ_OFFSET;
    m_shift = ffd_pkg::RST_SMOOTH_SHIFT;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at reset settings, then special settings
    foreach (dir_rows[r]) send_word(dir_rows[r].sample, dir_rows[r].typed, dir_rows[r].want);
    drain();
    write_reg(REG_NONE, 'h1FFF);
    set_all(1, 128, 128, 1000, 0);
    for (int j = 0; j < 12; j++) send_word((j % 2) ? 16'sh7FFF : 16'sh8000, 0, 0);
    drain();

    // random phases across idle modes, with one long receiver hold
    for (int p = 0; p < 8; p++) begin
      set_all(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3],
              phase_cfg[p][4]);
      idle_mode = idle_mode_t'(p % 4);
      for (int j = 0; j < 168; j++) begin
        if (p == 1 && j == 20) hold_req = 1;
        if (p == 1 && j == 21) hold_req = 0;
        send_word($urandom_range(3) == 0 ? (($urandom_range(1) == 1) ? 16'sh7FFF : 16'sh8000)
                                         : 16'($urandom), 0, 0);
      end
      drain();
    end

    $display("covered %0d words in, %0d out, across 8 register settings and 4 idle modes",
             words_in, words_out);
    $display("including a %0d-cycle output hold and writes to an unused index", HoldCycles);
    if (mismatches == 0) begin
      $display("[fractional_feedback_delay_top] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[fractional_feedback_delay_top] ERROR");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+src
src/ffd_pkg.sv
src/ffd_ram.sv
src/ffd_queue.sv
src/ffd_front.sv
src/ffd_back.sv
src/fractional_feedback_delay_top.sv
src/ffd_checker.sv
bench/tb_top.sv
